// ----- rtl/ple_pkg.sv -----
// Package for the positional list engine: sizes, request and status codes,
// and the per-cell select code. No dependencies; every rtl file imports it.
package ple_pkg;

    localparam int CAPACITY = 16;
    localparam int WORD_W   = 32;
    localparam int CNT_W    = 5;
    localparam int IDX_W    = 4;
    localparam int POS_W    = 8;
    localparam int OP_W     = 2;
    localparam int STAT_W   = 2;
    localparam int CMP_W    = POS_W + 1;
    localparam int IN_DATA_W  = 40;
    localparam int OUT_DATA_W = 40;

    typedef enum logic [OP_W-1:0] {
        OP_READ   = 2'd0,
        OP_INSERT = 2'd1,
        OP_DELETE = 2'd2,
        OP_UNUSED = 2'd3
    } op_t;

    typedef enum logic [STAT_W-1:0] {
        ST_DONE  = 2'd0,
        ST_RANGE = 2'd1,
        ST_FULL  = 2'd2,
        ST_NONE  = 2'd3
    } status_t;

    // What a cell loads in the current cycle.
    typedef enum logic [1:0] {
        SEL_HOLD  = 2'd0,
        SEL_LOAD  = 2'd1,
        SEL_LEFT  = 2'd2,
        SEL_RIGHT = 2'd3
    } cell_sel_t;

endpackage

// ----- rtl/ple_cell.sv -----
// One slot of the list: a word register that holds, loads a new word, or
// takes the word of its left or right neighbor. Depends on ple_pkg.
module ple_cell (
    input  logic                       clk,
    input  ple_pkg::cell_sel_t         sel,
    input  logic [ple_pkg::WORD_W-1:0] new_word,
    input  logic [ple_pkg::WORD_W-1:0] left_word,
    input  logic [ple_pkg::WORD_W-1:0] right_word,
    output logic [ple_pkg::WORD_W-1:0] word
);
    import ple_pkg::*;

    logic [WORD_W-1:0] word_reg;
    logic [WORD_W-1:0] word_next;

    always_comb
    begin
        case (sel)
            SEL_HOLD:  word_next = word_reg;
            SEL_LOAD:  word_next = new_word;
            SEL_LEFT:  word_next = left_word;
            SEL_RIGHT: word_next = right_word;
            default:   word_next = word_reg;
        endcase
    end

    // Payload only; contents are undefined until an insert writes them.
    always_ff @(posedge clk)
    begin
        word_reg <= word_next;
    end

    assign word = word_reg;

endmodule

// ----- rtl/positional_list_engine.sv -----
// Top level of the positional list engine: request decode, entry count,
// the row of slot cells and the result register. Depends on ple_pkg, ple_cell.
//
// Usage:
// Requests enter on the s_ channel. s_tuser carries the request kind
// (read, insert, delete) and s_tdata the 1-based position and the word to
// insert. Every request produces exactly one result on the m_ channel with
// a status, the word read by a successful read (zero otherwise) and the
// number of entries after the request.
// A request accepted at a clock edge has its result valid on m_tvalid
// right after that edge. Throughput is one request per cycle while
// m_tready takes results; the row of slot cells shifts all entries up or
// down in parallel, so a shift never holds up the flow.
// The result register is the only buffer. While a result waits, a new
// request is taken only in the cycle in which m_tready takes the old one,
// so a stalled receiver stalls the sender with no loss.
// Reset empties the list (count zero) and drops any pending result. Slot
// contents are not cleared; positions beyond the count are never read.
// An insert into a full list reports full; a position outside the valid
// range reports out of range and leaves the list unchanged.
module positional_list_engine (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           s_tvalid,
    output logic                           s_tready,
    // bits [7:0] position, bits [39:8] value
    input  logic [ple_pkg::IN_DATA_W-1:0]  s_tdata,
    // bits [1:0] op
    input  logic [ple_pkg::OP_W-1:0]       s_tuser,
    output logic                           m_tvalid,
    input  logic                           m_tready,
    // bits [1:0] status, bits [33:2] read_value, bits [38:34] count,
    // bit [39] zero
    output logic [ple_pkg::OUT_DATA_W-1:0] m_tdata
);
    import ple_pkg::*;

    logic [POS_W-1:0]  position;
    logic [WORD_W-1:0] value;
    op_t               op;
    logic              accept;

    logic [CNT_W-1:0]  entry_count_reg;
    logic [CNT_W-1:0]  entry_count_next;
    logic [CMP_W-1:0]  pos_ext;
    logic [CMP_W-1:0]  cnt_ext;
    logic              pos_nonzero;
    logic              is_full;
    logic              ins_ok;
    logic              del_ok;
    logic              rd_ok;

    status_t           status;
    logic [WORD_W-1:0] read_word;
    logic [IDX_W-1:0]  rd_idx;

    logic [WORD_W-1:0] cell_word [CAPACITY];
    cell_sel_t         cell_sel  [CAPACITY];

    logic              out_valid_reg;
    logic [OUT_DATA_W-1:0] out_data_reg;
    logic [OUT_DATA_W-1:0] out_data_next;

    assign position = s_tdata[POS_W-1:0];
    assign value    = s_tdata[POS_W +: WORD_W];
    assign op       = op_t'(s_tuser);

    // Take a request when the result register is empty or being drained.
    assign s_tready = !out_valid_reg || m_tready;
    assign accept   = s_tvalid && s_tready;

    // Range checks, all in one width wide enough for count + 1.
    assign pos_ext     = CMP_W'(position);
    assign cnt_ext     = CMP_W'(entry_count_reg);
    assign pos_nonzero = (position != '0);
    assign is_full     = (cnt_ext >= CMP_W'(CAPACITY));
    assign rd_ok  = (op == OP_READ) && pos_nonzero && (pos_ext <= cnt_ext);
    assign del_ok = (op == OP_DELETE) && pos_nonzero && (pos_ext <= cnt_ext);
    assign ins_ok = (op == OP_INSERT) && !is_full && pos_nonzero
                    && (pos_ext <= cnt_ext + CMP_W'(1));

    // Per-cell select. On insert the addressed cell loads the new word and
    // the cells above it, up to one past the old count, take their left
    // neighbor. On delete the cells from the addressed one up to the
    // second-to-last entry take their right neighbor.
    for (genvar i = 0; i < CAPACITY; i++)
    begin : g_sel
        localparam logic [CMP_W-1:0] CellPos = CMP_W'(i + 1);
        always_comb
        begin
            cell_sel[i] = SEL_HOLD;
            if (accept && ins_ok)
            begin
                if (CellPos == pos_ext)
                    cell_sel[i] = SEL_LOAD;
                else if (CellPos > pos_ext && CellPos <= cnt_ext + CMP_W'(1))
                    cell_sel[i] = SEL_LEFT;
            end
            else if (accept && del_ok)
            begin
                if (CellPos >= pos_ext && CellPos < cnt_ext)
                    cell_sel[i] = SEL_RIGHT;
            end
        end
    end

    // The row of cells; the ends see zero for their missing neighbor.
    for (genvar i = 0; i < CAPACITY; i++)
    begin : g_cell
        logic [WORD_W-1:0] left_w;
        logic [WORD_W-1:0] right_w;
        if (i == 0)
        begin : g_first
            assign left_w = '0;
        end
        else
        begin : g_left
            assign left_w = cell_word[i-1];
        end
        if (i == CAPACITY - 1)
        begin : g_last
            assign right_w = '0;
        end
        else
        begin : g_right
            assign right_w = cell_word[i+1];
        end
        ple_cell u_cell (
            .clk        (clk),
            .sel        (cell_sel[i]),
            .new_word   (value),
            .left_word  (left_w),
            .right_word (right_w),
            .word       (cell_word[i])
        );
    end

    // Read port: one mux over the row; the index is only used when in range.
    assign rd_idx    = IDX_W'(position - POS_W'(1));
    assign read_word = rd_ok ? cell_word[rd_idx] : '0;

    always_comb
    begin
        if (ins_ok || del_ok || rd_ok)
            status = ST_DONE;
        else if (op == OP_INSERT && is_full)
            status = ST_FULL;
        else
            status = ST_RANGE;
    end

    always_comb
    begin
        entry_count_next = entry_count_reg;
        if (accept && ins_ok)
            entry_count_next = entry_count_reg + CNT_W'(1);
        else if (accept && del_ok)
            entry_count_next = entry_count_reg - CNT_W'(1);
    end

    assign out_data_next = {1'b0, entry_count_next, read_word, status};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            entry_count_reg <= '0;
            out_valid_reg   <= 1'b0;
        end
        else
        begin
            entry_count_reg <= entry_count_next;
            if (accept)
                out_valid_reg <= 1'b1;
            else if (m_tready)
                out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
            out_data_reg <= out_data_next;
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;

endmodule

// ----- dv/ple_result_checker.sv -----
// Result checker for the positional list engine: watches both stream channels,
// predicts each result from its own copy of the list and compares it.
// Depends on ple_pkg for sizes and the request and status codes.
`timescale 1ns / 1ps

module ple_result_checker (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           s_tvalid,
    input  logic                           s_tready,
    input  logic [ple_pkg::IN_DATA_W-1:0]  s_tdata,
    input  logic [ple_pkg::OP_W-1:0]       s_tuser,
    input  logic                           m_tvalid,
    input  logic                           m_tready,
    input  logic [ple_pkg::OUT_DATA_W-1:0] m_tdata,
    output int                             mismatches,
    output int                             results_owed,
    output logic [ple_pkg::CNT_W-1:0]      list_fill
);
    import ple_pkg::*;

    typedef struct packed {
        status_t            status;
        logic [WORD_W-1:0]  word;
        logic [CNT_W-1:0]   fill;
    } list_result_t;

    // Shadow copy of the list; entries at or beyond list_fill are stale.
    logic [WORD_W-1:0] list_words [CAPACITY];
    list_result_t      pending_results [$];
    list_result_t      oldest;

    // Applies one request to the shadow list and returns the result it owes.
    function automatic list_result_t apply_request(op_t op, int pos, logic [WORD_W-1:0] word);
        list_result_t res;
        int           held;
        int           i;
        held       = int'(list_fill);
        res.status = ST_RANGE;
        res.word   = '0;
        case (op)
            OP_READ:
                if (pos >= 1 && pos <= held)
                begin
                    res.word   = list_words[pos - 1];
                    res.status = ST_DONE;
                end
            OP_INSERT:
                if (held >= CAPACITY)
                begin
                    res.status = ST_FULL;
                end
                else if (pos >= 1 && pos <= held + 1)
                begin
                    for (i = held; i >= pos; i--)
                    begin
                        list_words[i] = list_words[i - 1];
                    end
                    list_words[pos - 1] = word;
                    held++;
                    res.status = ST_DONE;
                end
            OP_DELETE:
                if (pos >= 1 && pos <= held)
                begin
                    for (i = pos; i < held; i++)
                    begin
                        list_words[i - 1] = list_words[i];
                    end
                    held--;
                    res.status = ST_DONE;
                end
            default:
                res.status = ST_RANGE;
        endcase
        list_fill = held[CNT_W-1:0];
        res.fill  = list_fill;
        return res;
    endfunction

    // A result is taken at a later edge than its request, so the result taken at an
    // edge is always checked before the request taken at the same edge is queued.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pending_results.delete();
            list_fill    = '0;
            mismatches   = 0;
            results_owed = 0;
        end
        else
        begin
            if (m_tvalid && m_tready)
            begin
                if (pending_results.size() == 0)
                begin
                    $error("result with no request waiting: m_tdata %h", m_tdata);
                    mismatches++;
                end
                else
                begin
                    oldest = pending_results.pop_front();
                    if (m_tdata[1:0] !== oldest.status)
                    begin
                        $error("status: expected %0d, actual %0d", oldest.status, m_tdata[1:0]);
                        mismatches++;
                    end
                    if (m_tdata[33:2] !== oldest.word)
                    begin
                        $error("read_value: expected %h, actual %h", oldest.word, m_tdata[33:2]);
                        mismatches++;
                    end
                    if (m_tdata[38:34] !== oldest.fill)
                    begin
                        $error("count: expected %0d, actual %0d", oldest.fill, m_tdata[38:34]);
                        mismatches++;
                    end
                    if (m_tdata[39] !== 1'b0)
                    begin
                        $error("pad: expected 0, actual %b", m_tdata[39]);
                        mismatches++;
                    end
                end
            end
            if (s_tvalid && s_tready)
            begin
                pending_results.push_back(apply_request(op_t'(s_tuser),
                                                        int'(s_tdata[POS_W-1:0]),
                                                        s_tdata[POS_W +: WORD_W]));
            end
            results_owed = pending_results.size();
        end
    end

endmodule

// ----- dv/tb_positional_list_engine.sv -----
// Testbench top for the positional list engine: clock, reset, request and
// result stimulus with random idling, and the verdict.
// Depends on ple_pkg, positional_list_engine and ple_result_checker.
`timescale 1ns / 1ps

module tb_positional_list_engine;
    import ple_pkg::*;

    // Mix of request kinds in one stretch of random traffic.
    typedef enum {MIX_FILL, MIX_DRAIN, MIX_BALANCED} traffic_mix_t;

    logic                  clk = 1'b0;
    logic                  rst_n = 1'b0;
    logic                  s_tvalid = 1'b0;
    logic                  s_tready;
    // bits [7:0] position, bits [39:8] value
    logic [IN_DATA_W-1:0]  s_tdata = '0;
    // bits [1:0] op
    logic [OP_W-1:0]       s_tuser = '0;
    logic                  m_tvalid;
    logic                  m_tready = 1'b0;
    // bits [1:0] status, bits [33:2] read_value, bits [38:34] count, bit [39] zero
    logic [OUT_DATA_W-1:0] m_tdata;

    int               mismatches;
    int               results_owed;
    logic [CNT_W-1:0] list_fill;

    int  requests_sent = 0;
    bit  gaps_on = 1'b1;
    int  stall_left = 0;
    int  calm_left = 0;
    int  stall_roll;

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    positional_list_engine i_dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    ple_result_checker i_result_checker (
        .clk          (clk),
        .rst_n        (rst_n),
        .s_tvalid     (s_tvalid),
        .s_tready     (s_tready),
        .s_tdata      (s_tdata),
        .s_tuser      (s_tuser),
        .m_tvalid     (m_tvalid),
        .m_tready     (m_tready),
        .m_tdata      (m_tdata),
        .mismatches   (mismatches),
        .results_owed (results_owed),
        .list_fill    (list_fill)
    );

    // Idle lengths: mostly none or short, now and then a long one.
    function automatic int idle_length();
        int roll;
        roll = $urandom_range(0, 99);
        if (roll < 50)
            return 0;
        else if (roll < 85)
            return $urandom_range(1, 3);
        else if (roll < 97)
            return $urandom_range(4, 10);
        else
            return $urandom_range(20, 60);
    endfunction

    // Receiver: random stalls, with calm stretches in which every result is
    // taken at once.
    always @(negedge clk)
    begin
        if (calm_left > 0)
        begin
            calm_left--;
            m_tready <= 1'b1;
        end
        else if (stall_left > 0)
        begin
            stall_left--;
            m_tready <= 1'b0;
        end
        else
        begin
            m_tready <= 1'b1;
            stall_roll = $urandom_range(0, 99);
            if (stall_roll < 3)
                calm_left = $urandom_range(50, 300);
            else if (stall_roll < 35)
                stall_left = idle_length();
        end
    end

    // Presents one request at the current falling edge and returns at the
    // falling edge after the block takes it, with s_tvalid still high.
    task automatic send_request(op_t op, logic [POS_W-1:0] pos, logic [WORD_W-1:0] word);
        s_tvalid <= 1'b1;
        s_tuser  <= op;
        s_tdata  <= {word, pos};
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);
        @(negedge clk);
    endtask

    task automatic sender_gap();
        int n;
        n = gaps_on ? idle_length() : 0;
        if (n > 0)
        begin
            s_tvalid <= 1'b0;
            repeat (n) @(negedge clk);
        end
    endtask

    // Holds the sender off until every request has been answered.
    task automatic wait_for_results();
        s_tvalid <= 1'b0;
        while (results_owed != 0)
            @(negedge clk);
    endtask

    // Builds one random request aimed at the list as it stands after every
    // request taken so far.
    task automatic random_request(traffic_mix_t mix);
        int               roll;
        int               fill;
        int               pick;
        op_t              op;
        logic [POS_W-1:0] pos;
        logic [WORD_W-1:0] word;
        fill = int'(list_fill);
        roll = $urandom_range(0, 99);
        case (mix)
            MIX_FILL:
                op = roll < 65 ? OP_INSERT : roll < 85 ? OP_READ :
                     roll < 97 ? OP_DELETE : OP_UNUSED;
            MIX_DRAIN:
                op = roll < 15 ? OP_INSERT : roll < 35 ? OP_READ :
                     roll < 97 ? OP_DELETE : OP_UNUSED;
            default:
                op = roll < 35 ? OP_INSERT : roll < 65 ? OP_READ :
                     roll < 95 ? OP_DELETE : OP_UNUSED;
        endcase
        roll = $urandom_range(0, 99);
        if (roll < 80)
        begin
            // A position that the request can actually use.
            if (op == OP_INSERT)
                pos = POS_W'($urandom_range(1, fill + 1));
            else
                pos = (fill == 0) ? POS_W'(1) : POS_W'($urandom_range(1, fill));
        end
        else if (roll < 88)
        begin
            // Just around the edges of the valid range.
            pick = $urandom_range(0, 3);
            pos  = (pick == 0) ? POS_W'(0) : POS_W'(fill + pick - 1);
        end
        else
        begin
            pos = POS_W'($urandom_range(0, 255));
        end
        roll = $urandom_range(0, 99);
        if (roll < 90)
        begin
            word = $urandom;
        end
        else
        begin
            pick = $urandom_range(0, 3);
            word = (pick == 0) ? 32'h0000_0000 : (pick == 1) ? 32'hFFFF_FFFF :
                   (pick == 2) ? 32'h8000_0000 : 32'h7FFF_FFFF;
        end
        send_request(op, pos, word);
        if (op != OP_UNUSED)
            requests_sent++;
    endtask

    initial
    begin
        int           phase;
        int           span;
        int           k;
        traffic_mix_t mix;

        repeat (8) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // Directed part: empty list, both ends and the middle, range edges,
        // the extremes of the word and the unused request kind.
        send_request(OP_READ,   8'd1,   32'h0);
        send_request(OP_DELETE, 8'd1,   32'h0);
        send_request(OP_INSERT, 8'd0,   32'h1234_5678);
        send_request(OP_INSERT, 8'd2,   32'h1234_5678);
        send_request(OP_INSERT, 8'd1,   32'h7FFF_FFFF);
        send_request(OP_INSERT, 8'd1,   32'h8000_0000);
        send_request(OP_INSERT, 8'd3,   32'h0000_0000);
        sender_gap();
        send_request(OP_INSERT, 8'd2,   32'hFFFF_FFFF);
        send_request(OP_INSERT, 8'd255, 32'hA5A5_A5A5);
        send_request(OP_READ,   8'd1,   32'h0);
        send_request(OP_READ,   8'd4,   32'hFFFF_FFFF);
        send_request(OP_READ,   8'd5,   32'h0);
        send_request(OP_READ,   8'd255, 32'h0);
        send_request(OP_READ,   8'd0,   32'h0);
        send_request(OP_UNUSED, 8'd1,   32'hFFFF_FFFF);
        sender_gap();
        send_request(OP_DELETE, 8'd2,   32'h0);
        send_request(OP_DELETE, 8'd3,   32'h0);
        send_request(OP_DELETE, 8'd0,   32'h0);
        send_request(OP_DELETE, 8'd128, 32'h0);
        send_request(OP_DELETE, 8'd1,   32'h0);
        send_request(OP_READ,   8'd1,   32'h0);
        send_request(OP_DELETE, 8'd1,   32'h0);
        send_request(OP_READ,   8'd1,   32'h0);
        wait_for_results();

        // Random part in stretches that push the list toward full, toward
        // empty, or keep it moving; the first stretch always pushes toward full.
        phase = 0;
        while (requests_sent < 1850)
        begin
            if (phase == 0)
                mix = MIX_FILL;
            else
                mix = traffic_mix_t'($urandom_range(0, 2));
            gaps_on = ($urandom_range(0, 3) != 0);
            span    = $urandom_range(40, 160);
            for (k = 0; k < span && requests_sent < 1850; k++)
            begin
                random_request(mix);
                sender_gap();
            end
            if ($urandom_range(0, 2) == 0)
                wait_for_results();
            phase++;
        end

        wait_for_results();
        repeat (4) @(negedge clk);
        if (mismatches == 0)
            $display("tb_positional_list_engine: PASS");
        else
            $display("tb_positional_list_engine: FAIL");
        $finish;
    end

    // Far beyond the slowest correct run, even with every idle at its longest.
    initial
    begin
        #20_000_000;
        $display("tb_positional_list_engine: FAIL");
        $finish;
    end

endmodule

// ----- filelist.f -----
rtl/ple_pkg.sv
rtl/ple_cell.sv
rtl/positional_list_engine.sv
dv/ple_result_checker.sv
dv/tb_positional_list_engine.sv
